// ===== design/nwa_pkg.sv =====
package nwa_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_STATE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINAL_MASK  = 1'd1;

    // Fixed field widths
    localparam int unsigned STATE_FIELD_W  = 4;
    localparam int unsigned SYMBOL_FIELD_W = 8;
    localparam int unsigned MASK_FIELD_W   = 16;
    localparam int unsigned S_TDATA_W      = 16;
    localparam int unsigned M_TDATA_W      = 8;

    // Input opcodes
    localparam logic OP_ADD_TRANS = 1'b0;
    localparam logic OP_SYMBOL    = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN,
        ST_FOLD,
        ST_FINISH
    } ctrl_state_t;

endpackage

// ===== design/nfa_word_acceptor_core.sv =====
// NFA word acceptor. Transitions and word symbols share one input stream: tuser selects
// adding a transition (0) or feeding a symbol (1), and tlast marks the final symbol of a
// word, which alone produces an output word with the accept bit. The next-state masks live
// in one memory of NUM_STATES * 2^SYMBOL_BITS entries with a single read port. After reset
// a clearing pass zeroes that memory, one entry per cycle; no input is taken during it,
// configuration writes are. An add-transition word is accepted, then read, then written
// back; an add that names a state out of range is dropped in its accept cycle. For a symbol
// word the memory port reads one next-state mask per state, and the masks of the states
// in the current set are folded into the new active set as the data returns. One word is
// processed at a time; a finished result sits in an output register so the next input
// word is accepted while it waits. A final symbol that finds an earlier result still
// unread holds in its last cycle until that result is taken.
module nfa_word_acceptor_core #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [nwa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [nwa_pkg::MASK_FIELD_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nwa_pkg::S_TDATA_W-1:0]       s_tdata,  // from_state[3:0], to_state[7:4],
                                                           // symbol[15:8]
    input  logic                                s_tuser,  // opcode[0]
    input  logic                                s_tlast,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nwa_pkg::M_TDATA_W-1:0]       m_tdata   // accepted[0], zeros above
);

    localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int AW    = SW + SYMBOL_BITS;
    localparam int DEPTH = NUM_STATES << SYMBOL_BITS;
    localparam int MW    = (NUM_STATES > nwa_pkg::MASK_FIELD_W) ?
                           NUM_STATES : nwa_pkg::MASK_FIELD_W;

    // Configuration registers
    logic [nwa_pkg::STATE_FIELD_W-1:0] start_state_reg;
    logic [nwa_pkg::MASK_FIELD_W-1:0]  final_mask_reg;

    // Controller and item registers
    nwa_pkg::ctrl_state_t state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg;
    logic [SW-1:0]          scan_cnt_reg;
    logic [SW-1:0]          from_reg;
    logic [SW-1:0]          to_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic                   last_reg;
    logic [NUM_STATES-1:0]  cur_set_reg;
    logic [NUM_STATES-1:0]  acc_reg;
    logic [NUM_STATES-1:0]  active_reg;
    logic                   at_start_reg;
    logic                   rd_pend_reg;
    logic                   hit_reg;
    logic                   m_tvalid_reg;
    logic                   m_accepted_reg;

    // Memory port signals
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [NUM_STATES-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [NUM_STATES-1:0] ram_rd_data;

    // Decoded input word
    logic                  s_accept;
    logic                  add_in_range;
    logic [NUM_STATES-1:0] start_set;
    logic                  scan_last;
    logic                  out_free;
    logic                  word_hit;

    assign s_accept     = s_tvalid && s_tready;
    assign add_in_range = (32'(s_tdata[3:0]) < 32'(NUM_STATES)) &&
                          (32'(s_tdata[7:4]) < 32'(NUM_STATES));
    assign start_set    = (32'(start_state_reg) < 32'(NUM_STATES)) ?
                          (NUM_STATES'(1) << SW'(start_state_reg)) : '0;
    assign scan_last    = (scan_cnt_reg == SW'(NUM_STATES - 1));
    assign out_free     = !m_tvalid_reg || m_tready;
    assign word_hit     = |(MW'(acc_reg) & MW'(final_mask_reg));

    nwa_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                nwa_pkg::CFG_START_STATE: begin
                    start_state_reg <= cfg_wdata[nwa_pkg::STATE_FIELD_W-1:0];
                end
                nwa_pkg::CFG_FINAL_MASK: begin
                    final_mask_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nwa_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = nwa_pkg::ST_IDLE;
                end
            end
            nwa_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == nwa_pkg::OP_SYMBOL) begin
                        state_next = nwa_pkg::ST_SCAN;
                    end else if (add_in_range) begin
                        state_next = nwa_pkg::ST_ADD_RD;
                    end
                end
            end
            nwa_pkg::ST_ADD_RD: state_next = nwa_pkg::ST_ADD_WR;
            nwa_pkg::ST_ADD_WR: state_next = nwa_pkg::ST_IDLE;
            nwa_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = nwa_pkg::ST_FOLD;
                end
            end
            nwa_pkg::ST_FOLD: state_next = nwa_pkg::ST_FINISH;
            nwa_pkg::ST_FINISH: begin
                if (!last_reg || out_free) begin
                    state_next = nwa_pkg::ST_IDLE;
                end
            end
            default: state_next = nwa_pkg::ST_CLEAR;
        endcase
    end

    // Handshake and memory controls
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_cnt_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = {from_reg, sym_reg};
        unique case (state_reg)
            nwa_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            nwa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            nwa_pkg::ST_ADD_RD: begin
                ram_rd_en = 1'b1;
            end
            nwa_pkg::ST_ADD_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = {from_reg, sym_reg};
                ram_wr_data = ram_rd_data | (NUM_STATES'(1) << to_reg);
            end
            nwa_pkg::ST_SCAN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = {scan_cnt_reg, sym_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nwa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sweep the table clear after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (state_reg == nwa_pkg::ST_CLEAR) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Latch the accepted word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            from_reg    <= SW'(s_tdata[3:0]);
            to_reg      <= SW'(s_tdata[7:4]);
            sym_reg     <= s_tdata[8 +: SYMBOL_BITS];
            last_reg    <= s_tlast;
            cur_set_reg <= at_start_reg ? start_set : active_reg;
        end
    end

    // Advance the scan over all states
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == nwa_pkg::ST_SCAN);
            if (s_accept) begin
                scan_cnt_reg <= '0;
            end else if (state_reg == nwa_pkg::ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= cur_set_reg[scan_cnt_reg];
    end

    // Fold returning masks into the new set
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            acc_reg <= '0;
        end else if (rd_pend_reg && hit_reg) begin
            acc_reg <= acc_reg | ram_rd_data;
        end
    end

    // Commit the word state at the end of a symbol
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            at_start_reg <= 1'b1;
        end else if (state_reg == nwa_pkg::ST_FINISH) begin
            if (!last_reg) begin
                active_reg   <= acc_reg;
                at_start_reg <= 1'b0;
            end else if (out_free) begin
                active_reg   <= '0;
                at_start_reg <= 1'b1;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == nwa_pkg::ST_FINISH && last_reg && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == nwa_pkg::ST_FINISH && last_reg && out_free) begin
            m_accepted_reg <= word_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(nwa_pkg::M_TDATA_W - 1)'(0), m_accepted_reg};

    // A result only appears after a final symbol has been folded
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == nwa_pkg::ST_FINISH && last_reg))
        else $error("result raised without a finished word");

    // No mask read is still in flight when the set is committed
    a_fold_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nwa_pkg::ST_FINISH) |-> !rd_pend_reg)
        else $error("active set committed before all masks returned");

    // A transition write back always follows its read
    a_add_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nwa_pkg::ST_ADD_WR) |-> $past(state_reg == nwa_pkg::ST_ADD_RD))
        else $error("transition written without a preceding read");

endmodule

// ===== design/nwa_ram.sv =====
module nwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ST      = 16;
    localparam int STALL_LIMIT = 20000;  // covers the clearing pass with margin
    localparam int SETTLE      = 40;     // outlasts the processing of a symbol word
    localparam int PHASE_WORDS = 250;

    typedef struct packed {
        logic                               opcode;
        logic [nwa_pkg::STATE_FIELD_W-1:0]  from_state;
        logic [nwa_pkg::STATE_FIELD_W-1:0]  to_state;
        logic [nwa_pkg::SYMBOL_FIELD_W-1:0] symbol;
        logic                               last;
    } nfa_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              cfg_wr_en = 1'b0;
    logic [nwa_pkg::CFG_ADDR_W-1:0]    cfg_addr  = '0;
    logic [nwa_pkg::MASK_FIELD_W-1:0]  cfg_wdata = '0;

    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // from_state[3:0], to_state[7:4], symbol[15:8]
    logic [nwa_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic                              s_tuser  = 1'b0; // opcode[0]
    logic                              s_tlast  = 1'b0;

    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [nwa_pkg::M_TDATA_W-1:0]     m_tdata;         // accepted[0], zeros above

    nfa_word_acceptor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow automaton: transition masks indexed by {from, symbol}
    logic [NUM_ST-1:0]                 trans_mem [NUM_ST * 256];
    logic [NUM_ST-1:0]                 live_set  = '0;
    logic                              at_start  = 1'b1;
    logic [nwa_pkg::STATE_FIELD_W-1:0] start_reg = '0;
    logic [nwa_pkg::MASK_FIELD_W-1:0]  final_reg = '0;

    nfa_item_t feed_q[$];
    logic      verdict_q[$];
    nfa_item_t cur_item;

    bit gaps_on   = 1'b1;
    int err_cnt   = 0;
    int sent_cnt  = 0;
    int words_chk = 0;
    int words_acc = 0;
    int stall_cnt = 0;

    task automatic flag_error(input string msg);
        $display("tb_top: MISMATCH %s", msg);
        err_cnt++;
    endtask

    // Advance the shadow automaton by one accepted word
    task automatic advance_nfa(input nfa_item_t it);
        logic [NUM_ST-1:0] cur;
        logic [NUM_ST-1:0] nxt;
        if (it.opcode == nwa_pkg::OP_ADD_TRANS) begin
            trans_mem[{it.from_state, it.symbol}][it.to_state] = 1'b1;
        end else begin
            cur = at_start ? (NUM_ST'(1) << start_reg) : live_set;
            nxt = '0;
            for (int s = 0; s < NUM_ST; s++) begin
                if (cur[s])
                    nxt |= trans_mem[{4'(s), it.symbol}];
            end
            if (it.last) begin
                verdict_q = {verdict_q, (|(nxt & final_reg))};
                live_set = '0;
                at_start = 1'b1;
            end else begin
                live_set = nxt;
                at_start = 1'b0;
            end
        end
    endtask

    function automatic void push_add(input int f, input int t, input int sym, input bit lst);
        nfa_item_t it;
        it.opcode     = nwa_pkg::OP_ADD_TRANS;
        it.from_state = 4'(f);
        it.to_state   = 4'(t);
        it.symbol     = 8'(sym);
        it.last       = lst;
        feed_q = {feed_q, it};
    endfunction

    function automatic void push_sym(input int sym, input bit lst);
        nfa_item_t it;
        it.opcode     = nwa_pkg::OP_SYMBOL;
        it.from_state = 4'($urandom_range(0, 15));  // don't-care bits, keep them moving
        it.to_state   = 4'($urandom_range(0, 15));
        it.symbol     = 8'(sym);
        it.last       = lst;
        feed_q = {feed_q, it};
    endfunction

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_nfa(cur_item);
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (feed_q.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 18)) begin
                    cur_item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.symbol, cur_item.to_state, cur_item.from_state};
                    s_tuser  <= cur_item.opcode;
                    s_tlast  <= cur_item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_error($sformatf("unexpected result, accepted=%0d", m_tdata[0]));
                end else begin
                    if (m_tdata[0] !== verdict_q[0])
                        flag_error($sformatf("word %0d: accepted got %0d expected %0d",
                                             words_chk, m_tdata[0], verdict_q[0]));
                    if (m_tdata[nwa_pkg::M_TDATA_W-1:1] !== '0)
                        flag_error($sformatf("word %0d: padding bits %0h",
                                             words_chk, m_tdata[nwa_pkg::M_TDATA_W-1:1]));
                    void'(verdict_q.pop_front());
                end
                words_chk++;
                if (m_tdata[0] === 1'b1)
                    words_acc++;
            end
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb_top: no progress for %0d cycles", STALL_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Write one register; only called with the block idle
    task automatic write_reg(input logic [nwa_pkg::CFG_ADDR_W-1:0]   idx,
                             input logic [nwa_pkg::MASK_FIELD_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == nwa_pkg::CFG_START_STATE)
            start_reg = val[nwa_pkg::STATE_FIELD_W-1:0];
        else
            final_reg = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until all words are in, all verdicts out, and the last symbol has settled
    task automatic wait_drain();
        do
            @(posedge aclk);
        while (feed_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Random words over a small alphabet, with stray symbols and adds mixed in
    task automatic build_random_phase(input int n_items);
        logic [7:0] alpha [4];
        int         left;
        int         len;
        int         roll;
        for (int i = 0; i < 4; i++) begin
            roll = $urandom_range(0, 7);
            alpha[i] = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        repeat ($urandom_range(8, 20))
            push_add($urandom_range(0, 15), $urandom_range(0, 15),
                     alpha[$urandom_range(0, 3)], $urandom_range(0, 1));
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    push_add($urandom_range(0, 15), $urandom_range(0, 15),
                             (roll < 2) ? $urandom_range(0, 255) : alpha[$urandom_range(0, 3)],
                             $urandom_range(0, 1));
                    left--;
                end
                push_sym((roll >= 8 && roll < 16) ? $urandom_range(0, 255)
                                                  : alpha[$urandom_range(0, 3)],
                         k == len - 1);
                left--;
            end
        end
    endtask

    initial begin
        foreach (trans_mem[i])
            trans_mem[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration, empty table: word is rejected
        push_sym(8'h00, 1'b1);
        wait_drain();

        // Start 3, accept 5
        write_reg(nwa_pkg::CFG_START_STATE, 16'd3);
        write_reg(nwa_pkg::CFG_FINAL_MASK, 16'h0020);
        push_add(3, 5, 8'h61, 1'b0);
        push_sym(8'h61, 1'b1);                  // accepting state with no outgoing moves
        push_sym(8'h61, 1'b0);
        push_sym(8'h61, 1'b1);                  // set runs empty and stays empty
        push_add(5, 7, 8'h62, 1'b1);            // tlast on an add is ignored
        push_sym(8'h61, 1'b0);
        push_add(5, 5, 8'h63, 1'b0);            // add in the middle of a word
        push_sym(8'h63, 1'b1);
        push_sym(8'h61, 1'b0);
        push_sym(8'h62, 1'b1);                  // ends in non-accepting state 7
        push_add(15, 0, 8'hFF, 1'b0);
        push_add(0, 15, 8'h00, 1'b0);
        push_add(3, 15, 8'hFF, 1'b1);
        wait_drain();

        // Start 15, all states accepting
        write_reg(nwa_pkg::CFG_START_STATE, 16'd15);
        write_reg(nwa_pkg::CFG_FINAL_MASK, 16'hFFFF);
        push_sym(8'hFF, 1'b1);
        push_sym(8'hFF, 1'b0);
        push_sym(8'h00, 1'b1);
        push_sym(8'h80, 1'b1);
        wait_drain();

        // Random phases across several settings, one without any gaps
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(nwa_pkg::CFG_START_STATE, 16'd0);
                    write_reg(nwa_pkg::CFG_FINAL_MASK, 16'h0000);
                end
                1: begin
                    write_reg(nwa_pkg::CFG_START_STATE, 16'd15);
                    write_reg(nwa_pkg::CFG_FINAL_MASK, 16'hFFFF);
                end
                2, 5: begin
                    write_reg(nwa_pkg::CFG_START_STATE, 16'($urandom_range(0, 15)));
                    write_reg(nwa_pkg::CFG_FINAL_MASK, (16'd1 << $urandom_range(0, 15)) |
                                                       (16'd1 << $urandom_range(0, 15)));
                end
                default: begin
                    write_reg(nwa_pkg::CFG_START_STATE, 16'($urandom_range(0, 15)));
                    write_reg(nwa_pkg::CFG_FINAL_MASK, 16'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            gaps_on = (ph != 3);
            build_random_phase(PHASE_WORDS);
            wait_drain();
        end

        $display("tb_top: %0d input words sent over 11 settings, %0d verdicts checked",
                 sent_cnt, words_chk);
        $display("tb_top: %0d words accepted, %0d rejected", words_acc, words_chk - words_acc);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
